// ===== hw/rtl/kdll_pkg.sv =====
// Shared types, command codes and helpers for the keyed doubly linked list.
`default_nettype none

package kdll_pkg;

    // Number of key slots; key 0 is the null link.
    localparam int KEYS  = 64;
    localparam int KEY_W = 6;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [1:0]       t_cmd;

    // Command codes.
    localparam t_cmd CMD_APPEND = 2'd0;
    localparam t_cmd CMD_INSERT = 2'd1;
    localparam t_cmd CMD_DELETE = 2'd2;
    localparam t_cmd CMD_READ   = 2'd3;

    // Read-out position at which the walk is forced to stop.
    localparam t_key CNT_LAST = KEY_W'(KEYS - 2);

    // One input request.
    typedef struct packed {
        t_cmd command;
        t_key anchor_key;
        t_key new_key;
    } t_in_req;

    // One result.
    typedef struct packed {
        t_key element;
        logic last;
    } t_out_res;

    // A classified command on its way from the front to the back.
    typedef struct packed {
        t_cmd op;
        t_key a;
        t_key b;
    } t_op;

    // List status exported by the back part.
    typedef struct packed {
        t_key head;
        t_key tail;
    } t_bk_stat;

    // A key names a real slot when it is nonzero and below the slot count.
    function automatic logic key_ok(input t_key k);
        return (k != '0) && ((KEY_W + 1)'(k) < (KEY_W + 1)'(KEYS));
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/kdll_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module kdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/kdll_front.sv =====
// Front part: takes requests, drops ones with bad keys, and queues the rest.
`default_nettype none

module kdll_front import kdll_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    output logic         o_full,
    input  wire t_in_req i_req,
    output logic         o_op_valid,
    output t_op          o_op,
    input  wire logic    i_op_pop
);

    t_op        r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       w_keep;
    logic       w_wr;
    logic       w_rd;
    t_op        w_op;

    // Static checks that do not depend on the list contents.
    always_comb begin
        unique case (i_req.command)
            CMD_APPEND: w_keep = key_ok(i_req.anchor_key);
            CMD_INSERT: w_keep = key_ok(i_req.anchor_key) && key_ok(i_req.new_key);
            CMD_DELETE: w_keep = key_ok(i_req.anchor_key);
            CMD_READ:   w_keep = 1'b1;
            default:    w_keep = 1'b0;
        endcase
        w_op.op = i_req.command;
        w_op.a  = i_req.anchor_key;
        w_op.b  = i_req.new_key;
    end

    assign o_full     = (r_cnt == 2'd2);
    assign o_op_valid = (r_cnt != 2'd0);
    assign o_op       = r_q[r_rptr];
    assign w_wr       = i_push && !o_full && w_keep;
    assign w_rd       = i_op_pop && o_op_valid;

    // Two-entry command queue: pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wptr <= ~r_wptr;
            end
            if (w_rd) begin
                r_rptr <= ~r_rptr;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wptr] <= w_op;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/kdll_outq.sv =====
// Two-entry result queue that drives the result side of the block.
`default_nettype none

module kdll_outq import kdll_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_out_res i_res,
    output logic          o_full,
    output logic          o_empty,
    input  wire logic     i_pop,
    output t_out_res      o_res
);

    t_out_res   r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_q[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wptr <= ~r_wptr;
            end
            if (w_rd) begin
                r_rptr <= ~r_rptr;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wptr] <= i_res;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/kdll_back.sv =====
// Back part: link tables, present bits, head and tail, and the command sequencer.
`default_nettype none

module kdll_back import kdll_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_op_valid,
    input  wire t_op  i_op,
    output logic      o_op_pop,
    input  wire logic i_res_full,
    output logic      o_res_push,
    output t_out_res  o_res,
    output t_bk_stat  o_stat
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_APP  = 3'd1;
    localparam logic [2:0] S_INS1 = 3'd2;
    localparam logic [2:0] S_INS2 = 3'd3;
    localparam logic [2:0] S_DEL  = 3'd4;
    localparam logic [2:0] S_WALK = 3'd5;

    logic [2:0]      r_state, n_state;
    t_key            r_head, n_head;
    t_key            r_tail, n_tail;
    logic [KEYS-1:0] r_present, n_present;
    t_key            r_cnt, n_cnt;
    t_key            r_key, n_key;
    t_key            r_key2, n_key2;
    t_key            r_nx, n_nx;

    logic nx_we;
    t_key nx_waddr, nx_wdata, nx_raddr, nx_rdata;
    logic pv_we;
    t_key pv_waddr, pv_wdata, pv_raddr, pv_rdata;
    logic w_last;

    // Next and previous link tables.
    kdll_ram #(.WIDTH(KEY_W), .DEPTH(KEYS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_raddr (nx_raddr),
        .o_rdata (nx_rdata)
    );

    kdll_ram #(.WIDTH(KEY_W), .DEPTH(KEYS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_raddr (pv_raddr),
        .o_rdata (pv_rdata)
    );

    // During a walk the key under the cursor is the final one of the run.
    assign w_last = (nx_rdata == '0) || (r_cnt == CNT_LAST);

    assign o_stat.head = r_head;
    assign o_stat.tail = r_tail;

    // Command sequencer.
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_present  = r_present;
        n_cnt      = r_cnt;
        n_key      = r_key;
        n_key2     = r_key2;
        n_nx       = r_nx;
        o_op_pop   = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        nx_we      = 1'b0;
        nx_waddr   = r_key;
        nx_wdata   = '0;
        nx_raddr   = i_op.a;
        pv_we      = 1'b0;
        pv_waddr   = r_key;
        pv_wdata   = '0;
        pv_raddr   = i_op.a;

        unique case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    case (i_op.op)
                        CMD_APPEND: begin
                            o_op_pop = 1'b1;
                            if (!r_present[i_op.a]) begin
                                // The new tail links back to the old one.
                                nx_we    = 1'b1;
                                nx_waddr = i_op.a;
                                nx_wdata = '0;
                                pv_we    = 1'b1;
                                pv_waddr = i_op.a;
                                pv_wdata = r_tail;
                                n_key    = i_op.a;
                                n_state  = S_APP;
                            end
                        end
                        CMD_INSERT: begin
                            o_op_pop = 1'b1;
                            if (r_present[i_op.a] && !r_present[i_op.b]) begin
                                n_key   = i_op.a;
                                n_key2  = i_op.b;
                                n_state = S_INS1;
                            end
                        end
                        CMD_DELETE: begin
                            o_op_pop = 1'b1;
                            if (r_present[i_op.a]) begin
                                n_key   = i_op.a;
                                n_state = S_DEL;
                            end
                        end
                        default: begin
                            // Read out: an empty list gives one null result.
                            if (r_head == '0) begin
                                if (!i_res_full) begin
                                    o_op_pop      = 1'b1;
                                    o_res_push    = 1'b1;
                                    o_res.element = '0;
                                    o_res.last    = 1'b1;
                                end
                            end else begin
                                o_op_pop = 1'b1;
                                nx_raddr = r_head;
                                n_key    = r_head;
                                n_cnt    = '0;
                                n_state  = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_APP: begin
                if (r_tail != '0) begin
                    nx_we    = 1'b1;
                    nx_waddr = r_tail;
                    nx_wdata = r_key;
                end else begin
                    n_head = r_key;
                end
                n_tail           = r_key;
                n_present[r_key] = 1'b1;
                n_state          = S_IDLE;
            end
            S_INS1: begin
                // Splice the new key in behind the anchor.
                n_nx     = nx_rdata;
                nx_we    = 1'b1;
                nx_waddr = r_key;
                nx_wdata = r_key2;
                pv_we    = 1'b1;
                pv_waddr = r_key2;
                pv_wdata = r_key;
                n_state  = S_INS2;
            end
            S_INS2: begin
                nx_we    = 1'b1;
                nx_waddr = r_key2;
                nx_wdata = r_nx;
                if (r_nx != '0) begin
                    pv_we    = 1'b1;
                    pv_waddr = r_nx;
                    pv_wdata = r_key2;
                end else begin
                    n_tail = r_key2;
                end
                n_present[r_key2] = 1'b1;
                n_state           = S_IDLE;
            end
            S_DEL: begin
                // Join the neighbors of the removed key.
                if (pv_rdata != '0) begin
                    nx_we    = 1'b1;
                    nx_waddr = pv_rdata;
                    nx_wdata = nx_rdata;
                end else begin
                    n_head = nx_rdata;
                end
                if (nx_rdata != '0) begin
                    pv_we    = 1'b1;
                    pv_waddr = nx_rdata;
                    pv_wdata = pv_rdata;
                end else begin
                    n_tail = pv_rdata;
                end
                n_present[r_key] = 1'b0;
                n_state          = S_IDLE;
            end
            S_WALK: begin
                // The link of the cursor key is on the read port; reread on a stall.
                nx_raddr = r_key;
                if (!i_res_full) begin
                    o_res_push    = 1'b1;
                    o_res.element = r_key;
                    o_res.last    = w_last;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        nx_raddr = nx_rdata;
                        n_key    = nx_rdata;
                        n_cnt    = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_present <= '0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_present <= n_present;
            r_cnt     <= n_cnt;
        end
    end

    // Working keys of the current command.
    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_key2 <= n_key2;
        r_nx   <= n_nx;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/keyed_doubly_linked_list_top.sv =====
// Top level of the keyed doubly linked list: front, back and result queue.
// A request is stored in the front queue before the back can take it; a read-out
// result passes through the result queue before it reaches the result side.
// In the back, append steps through S_APP, insert through S_INS1 and S_INS2, delete
// through S_DEL; a read out walks keys in S_WALK via the single next-link read port.
// Reset (synchronous, active low) empties both queues, the list and all present bits.
`default_nettype none

module keyed_doubly_linked_list_top import kdll_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_req  i_req,
    output logic          empty,
    input  wire logic     pop,
    output t_out_res      o_res
);

    logic     op_valid;
    t_op      op;
    logic     op_pop;
    logic     res_full;
    logic     res_push;
    t_out_res res;
    t_bk_stat stat;

    kdll_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_req      (i_req),
        .o_op_valid (op_valid),
        .o_op       (op),
        .i_op_pop   (op_pop)
    );

    kdll_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .i_op       (op),
        .o_op_pop   (op_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res),
        .o_stat     (stat)
    );

    kdll_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res),
        .o_full  (res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (o_res)
    );

    // A null element only comes from an empty read out, which is always final.
    a_null_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.element == '0) |-> o_res.last)
        else $error("null result without last mark");

    // Head and tail are null together.
    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.head == '0) == (stat.tail == '0))
        else $error("head and tail disagree on an empty list");

    // The back never pushes a result into a full result queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_full |-> !res_push)
        else $error("result pushed while result queue full");

    // Coming out of reset the result side is empty.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> empty)
        else $error("results present right after reset");

endmodule

`default_nettype wire
